/* sv/grid_axis_reduce_expand_defines.svh */
// ----------------------------------------------------------------------------
// grid_axis_reduce_expand_defines
// assertion macros used by the checker file gare_checker
// ----------------------------------------------------------------------------
`ifndef GRID_AXIS_REDUCE_EXPAND_DEFINES_SVH
`define GRID_AXIS_REDUCE_EXPAND_DEFINES_SVH

// same-cycle implication, off while in reset
`define GARE_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, off while in reset
`define GARE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// holds in the cycle after any reset cycle
`define GARE_ASSERT_RESET(label, cons, msg) \
  label: assert property (@(posedge clk) rst |=> (cons)) else $error(msg);

`endif

/* sv/gare_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gare_pkg
// types and constants of the grid axis reduce / expand block
// ----------------------------------------------------------------------------
package gare_pkg;

  localparam int SAMPLE_W    = 16;
  localparam int VALUE_W     = 28;
  localparam int POS_W       = 6;
  localparam int CNT_W       = 7;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 7;
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
  localparam int DIV_STEPS   = VALUE_W;
  localparam int DIV_CNT_W   = $clog2(DIV_STEPS);

  localparam logic [CNT_W-1:0] SIZE_RESET = 7'd64;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_DIRECTION   = 3'd0,
    CFG_KEEP_AXIS   = 3'd1,
    CFG_REDUCE_MODE = 3'd2,
    CFG_SIZE_X      = 3'd3,
    CFG_SIZE_Y      = 3'd4
  } cfg_index_t;

  typedef enum logic [1:0] {
    MODE_SUM = 2'd0,
    MODE_AVG = 2'd1,
    MODE_MAX = 2'd2,
    MODE_MIN = 2'd3
  } mode_t;

  typedef enum logic [1:0] {
    CMD_EMIT   = 2'd0,
    CMD_DIVIDE = 2'd1,
    CMD_EXPAND = 2'd2
  } cmd_kind_t;

  typedef enum logic {
    F_IDLE = 1'b0,
    F_COL  = 1'b1
  } front_state_t;

  typedef enum logic [1:0] {
    B_IDLE = 2'd0,
    B_DIV  = 2'd1,
    B_OUT  = 2'd2,
    B_EXP  = 2'd3
  } back_state_t;

  typedef struct packed {
    logic             direction;
    logic             keep_axis;
    mode_t            reduce_mode;
    logic [CNT_W-1:0] size_x;
    logic [CNT_W-1:0] size_y;
  } cfg_t;

  // one unit of work handed from front to back
  typedef struct packed {
    cmd_kind_t                  kind;
    logic signed [VALUE_W-1:0]  value;
    logic [POS_W-1:0]           x;
    logic [POS_W-1:0]           y;
    logic [CNT_W-1:0]           count;
    logic                       axis;
  } cmd_t;

endpackage

/* sv/gare_if.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gare_if
// channel interfaces: sample input, result output, register writes
// ----------------------------------------------------------------------------
interface gare_in_if import gare_pkg::*;;
  logic                       valid;
  logic                       ready;
  logic signed [SAMPLE_W-1:0] sample;

  modport source (output valid, output sample, input ready);
  modport sink   (input valid, input sample, output ready);
endinterface

interface gare_out_if import gare_pkg::*;;
  logic                      valid;
  logic                      ready;
  logic signed [VALUE_W-1:0] value;
  logic [POS_W-1:0]          x_index;
  logic [POS_W-1:0]          y_index;
  logic                      last;

  modport source (output valid, output value, output x_index, output y_index,
                  output last, input ready);
  modport sink   (input valid, input value, input x_index, input y_index,
                  input last, output ready);
endinterface

interface gare_cfg_if import gare_pkg::*;;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source (output valid, output index, output data, input ready);
  modport sink   (input valid, input index, input data, output ready);
endinterface

/* sv/gare_queue.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gare_queue
// short command queue between front and back
// ----------------------------------------------------------------------------
module gare_queue import gare_pkg::*; (
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  cmd_t push_cmd,
  output logic full,
  input  logic pop,
  output cmd_t head,
  output logic empty
);

  cmd_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QPTR_W:0]   fill;
  logic              do_push;
  logic              do_pop;

  assign full    = (fill == (QPTR_W + 1)'(QUEUE_DEPTH));
  assign empty   = (fill == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slots[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      fill   <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + QPTR_W'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + QPTR_W'(1);
      end
      case ({do_push, do_pop})
        2'b10:   fill <= fill + (QPTR_W + 1)'(1);
        2'b01:   fill <= fill - (QPTR_W + 1)'(1);
        default: fill <= fill;
      endcase
    end
  end

endmodule

/* sv/gare_front.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gare_front
// takes samples, tracks grid position, runs the row and column reductions and issues expand commands
// ----------------------------------------------------------------------------
module gare_front import gare_pkg::*; #(
  parameter int MAX_SIZE = 64
) (
  input  logic          clk,
  input  logic          rst,
  input  cfg_t          cfg,
  gare_in_if.sink       samples,
  input  logic          q_full,
  output logic          push,
  output cmd_t          push_cmd
);

  localparam int AW = (MAX_SIZE > 1) ? $clog2(MAX_SIZE) : 1;

  front_state_t              state;
  front_state_t              state_next;
  logic [POS_W-1:0]          row_pos;
  logic [POS_W-1:0]          col_pos;
  logic signed [VALUE_W-1:0] row_acc;
  logic signed [VALUE_W-1:0] col_mem [MAX_SIZE];
  logic signed [VALUE_W-1:0] col_rd;

  // held for the column read-modify-write
  logic signed [VALUE_W-1:0] hold_v;
  logic                      hold_first;
  logic                      hold_end;
  logic [POS_W-1:0]          hold_y;
  logic [CNT_W-1:0]          hold_sx;
  mode_t                     hold_mode;

  logic [CNT_W-1:0]          sx;
  logic [CNT_W-1:0]          sy;
  logic signed [VALUE_W-1:0] v;
  logic                      row_end;
  logic                      col_end;
  logic                      accept;
  logic signed [VALUE_W-1:0] row_new;
  logic signed [VALUE_W-1:0] col_new;

  function automatic logic [CNT_W-1:0] eff_size(input logic [CNT_W-1:0] s);
    if (s == '0) begin
      eff_size = CNT_W'(1);
    end else if (s > CNT_W'(MAX_SIZE)) begin
      eff_size = CNT_W'(MAX_SIZE);
    end else begin
      eff_size = s;
    end
  endfunction

  function automatic logic signed [VALUE_W-1:0] combine(
    input mode_t                     mode,
    input logic signed [VALUE_W-1:0] acc,
    input logic signed [VALUE_W-1:0] smp
  );
    case (mode)
      MODE_MAX: combine = (smp > acc) ? smp : acc;
      MODE_MIN: combine = (smp < acc) ? smp : acc;
      default:  combine = acc + smp;
    endcase
  endfunction

  assign sx      = eff_size(cfg.size_x);
  assign sy      = eff_size(cfg.size_y);
  assign v       = {{(VALUE_W - SAMPLE_W){samples.sample[SAMPLE_W-1]}}, samples.sample};
  assign row_end = (CNT_W'(col_pos) + CNT_W'(1)) >= sy;
  assign col_end = (CNT_W'(row_pos) + CNT_W'(1)) >= sx;
  assign accept  = samples.valid && samples.ready;
  assign row_new = (col_pos == '0) ? v : combine(cfg.reduce_mode, row_acc, v);
  assign col_new = hold_first ? hold_v : combine(hold_mode, col_rd, hold_v);

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= F_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next    = state;
    samples.ready = 1'b0;
    push          = 1'b0;
    push_cmd      = '0;
    case (state)
      F_IDLE: begin
        samples.ready = !q_full;
        if (accept) begin
          if (cfg.direction) begin
            push           = 1'b1;
            push_cmd.kind  = CMD_EXPAND;
            push_cmd.value = v;
            push_cmd.axis  = cfg.keep_axis;
            if (!cfg.keep_axis) begin
              push_cmd.x     = row_pos;
              push_cmd.count = sy;
            end else begin
              push_cmd.y     = col_pos;
              push_cmd.count = sx;
            end
          end else if (!cfg.keep_axis) begin
            push           = row_end;
            push_cmd.kind  = (cfg.reduce_mode == MODE_AVG) ? CMD_DIVIDE : CMD_EMIT;
            push_cmd.value = row_new;
            push_cmd.x     = row_pos;
            push_cmd.count = sy;
          end else begin
            state_next = F_COL;
          end
        end
      end
      F_COL: begin
        push           = hold_end;
        push_cmd.kind  = (hold_mode == MODE_AVG) ? CMD_DIVIDE : CMD_EMIT;
        push_cmd.value = col_new;
        push_cmd.y     = hold_y;
        push_cmd.count = hold_sx;
        state_next     = F_IDLE;
      end
      default: state_next = F_IDLE;
    endcase
  end

  // grid position and row accumulator
  always_ff @(posedge clk) begin
    if (rst) begin
      row_pos <= '0;
      col_pos <= '0;
      row_acc <= '0;
    end else if (accept) begin
      if (cfg.direction) begin
        if (!cfg.keep_axis) begin
          row_pos <= col_end ? '0 : row_pos + POS_W'(1);
        end else begin
          col_pos <= row_end ? '0 : col_pos + POS_W'(1);
        end
      end else begin
        if (!cfg.keep_axis) begin
          row_acc <= row_new;
        end
        if (row_end) begin
          col_pos <= '0;
          row_pos <= col_end ? '0 : row_pos + POS_W'(1);
        end else begin
          col_pos <= col_pos + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hold_v     <= v;
      hold_first <= (row_pos == '0);
      hold_end   <= col_end;
      hold_y     <= col_pos;
      hold_sx    <= sx;
      hold_mode  <= cfg.reduce_mode;
    end
  end

  // column accumulators: read on accept, written back in the F_COL state that follows
  always_ff @(posedge clk) begin
    if (accept) begin
      col_rd <= col_mem[col_pos[AW-1:0]];
    end
    if (state == F_COL) begin
      col_mem[hold_y[AW-1:0]] <= col_new;
    end
  end

endmodule

/* sv/gare_div.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gare_div
// signed by unsigned divider, one quotient bit per cycle, truncates to zero
// ----------------------------------------------------------------------------
module gare_div import gare_pkg::*; (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      start,
  input  logic signed [VALUE_W-1:0] dividend,
  input  logic [CNT_W-1:0]          divisor,
  output logic                      done,
  output logic signed [VALUE_W-1:0] quotient
);

  logic                 busy;
  logic [DIV_CNT_W-1:0] step;
  logic [CNT_W-1:0]     rem;
  logic [CNT_W-1:0]     dvs;
  logic [VALUE_W-1:0]   quo;
  logic                 neg;
  logic [CNT_W:0]       trial;
  logic                 ge;
  logic [CNT_W:0]       diff;

  assign trial    = {rem, quo[VALUE_W-1]};
  assign ge       = trial >= {1'b0, dvs};
  assign diff     = trial - {1'b0, dvs};
  assign quotient = neg ? VALUE_W'(-quo) : VALUE_W'(quo);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        busy <= 1'b1;
      end else if (busy && step == DIV_CNT_W'(DIV_STEPS - 1)) begin
        busy <= 1'b0;
        done <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      step <= '0;
      rem  <= '0;
      dvs  <= divisor;
      neg  <= dividend[VALUE_W-1];
      quo  <= dividend[VALUE_W-1] ? VALUE_W'(-dividend) : VALUE_W'(dividend);
    end else if (busy) begin
      step <= step + DIV_CNT_W'(1);
      rem  <= ge ? diff[CNT_W-1:0] : trial[CNT_W-1:0];
      quo  <= {quo[VALUE_W-2:0], ge};
    end
  end

endmodule

/* sv/gare_back.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gare_back
// executes queued commands: single results, averages, line copies
// ----------------------------------------------------------------------------
module gare_back import gare_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  cmd_t       head,
  input  logic       q_empty,
  output logic       pop,
  gare_out_if.source results
);

  back_state_t               state;
  back_state_t               state_next;
  cmd_t                      work;
  logic [POS_W-1:0]          idx;
  logic [POS_W-1:0]          idx_next;

  logic                      out_valid;
  logic signed [VALUE_W-1:0] out_value;
  logic [POS_W-1:0]          out_x;
  logic [POS_W-1:0]          out_y;
  logic                      out_last;

  logic                      slot_free;
  logic                      load;
  logic [POS_W-1:0]          ld_x;
  logic [POS_W-1:0]          ld_y;
  logic                      ld_last;
  logic                      div_start;
  logic                      div_done;
  logic signed [VALUE_W-1:0] div_quotient;

  gare_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (head.value),
    .divisor  (head.count),
    .done     (div_done),
    .quotient (div_quotient)
  );

  assign slot_free       = !out_valid || results.ready;
  assign results.valid   = out_valid;
  assign results.value   = out_value;
  assign results.x_index = out_x;
  assign results.y_index = out_y;
  assign results.last    = out_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= B_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    pop        = 1'b0;
    div_start  = 1'b0;
    load       = 1'b0;
    idx_next   = idx;
    ld_x       = work.x;
    ld_y       = work.y;
    ld_last    = 1'b1;
    case (state)
      B_IDLE: begin
        if (!q_empty) begin
          pop = 1'b1;
          case (head.kind)
            CMD_DIVIDE: begin
              div_start  = 1'b1;
              state_next = B_DIV;
            end
            CMD_EXPAND: begin
              idx_next   = '0;
              state_next = B_EXP;
            end
            default: state_next = B_OUT;
          endcase
        end
      end
      B_DIV: begin
        if (div_done) begin
          state_next = B_OUT;
        end
      end
      B_OUT: begin
        if (slot_free) begin
          load       = 1'b1;
          state_next = B_IDLE;
        end
      end
      B_EXP: begin
        ld_x    = work.axis ? idx : work.x;
        ld_y    = work.axis ? work.y : idx;
        ld_last = (CNT_W'(idx) + CNT_W'(1)) == work.count;
        if (slot_free) begin
          load     = 1'b1;
          idx_next = idx + POS_W'(1);
          if (ld_last) begin
            state_next = B_IDLE;
          end
        end
      end
      default: state_next = B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    idx <= idx_next;
    if (pop) begin
      work <= head;
    end else if (state == B_DIV && div_done) begin
      work.value <= div_quotient;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= 1'b1;
    end else if (results.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      out_value <= work.value;
      out_x     <= ld_x;
      out_y     <= ld_y;
      out_last  <= ld_last;
    end
  end

endmodule

/* sv/grid_axis_reduce_expand.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// grid_axis_reduce_expand
// reduces a grid along one axis, or expands a line over the grid
// ----------------------------------------------------------------------------
//  channel   dir  payload                             request
//  cfg       in   index[2:0], data[6:0]               one register write
//  samples   in   sample (s16, q8.8)                  one grid or line sample
//  results   out  value (s28, q20.8), x_index,        one reduced or copied
//                 y_index, last                       value
//
//  front takes one sample per cycle while the queue has room; when reducing
//  with y kept it pauses in F_COL for the column accumulator read-modify-write
//  averages use the bit-serial divider in the back end; unless results stall,
//  expand emits size_y (keep x) or size_x (keep y) results, one per cycle
//  synchronous reset clears positions, row accumulator and registers; the
//  column accumulators are not cleared; either side may stall at any time
// ----------------------------------------------------------------------------
module grid_axis_reduce_expand import gare_pkg::*; #(
  parameter int MAX_SIZE = 64
) (
  input  logic       clk,
  input  logic       rst,
  gare_cfg_if.sink   cfg,
  gare_in_if.sink    samples,
  gare_out_if.source results
);

  // configuration registers
  cfg_t cfg_regs;

  // front to back command queue
  logic q_push;
  cmd_t q_push_cmd;
  logic q_full;
  logic q_pop;
  cmd_t q_head;
  logic q_empty;

  // writes are always taken; unknown indexes are dropped
  assign cfg.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg_regs.direction   <= 1'b0;
      cfg_regs.keep_axis   <= 1'b0;
      cfg_regs.reduce_mode <= MODE_SUM;
      cfg_regs.size_x      <= SIZE_RESET;
      cfg_regs.size_y      <= SIZE_RESET;
    end else if (cfg.valid) begin
      case (cfg.index)
        CFG_DIRECTION:   cfg_regs.direction   <= cfg.data[0];
        CFG_KEEP_AXIS:   cfg_regs.keep_axis   <= cfg.data[0];
        CFG_REDUCE_MODE: cfg_regs.reduce_mode <= mode_t'(cfg.data[1:0]);
        CFG_SIZE_X:      cfg_regs.size_x      <= cfg.data;
        CFG_SIZE_Y:      cfg_regs.size_y      <= cfg.data;
        default: ;
      endcase
    end
  end

  // front: grid position, accumulation, command issue
  gare_front #(
    .MAX_SIZE (MAX_SIZE)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .cfg      (cfg_regs),
    .samples  (samples),
    .q_full   (q_full),
    .push     (q_push),
    .push_cmd (q_push_cmd)
  );

  // decouples sample intake from result delivery
  gare_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .full     (q_full),
    .pop      (q_pop),
    .head     (q_head),
    .empty    (q_empty)
  );

  // back: divider, line copy sequencer, output register
  gare_back u_back (
    .clk     (clk),
    .rst     (rst),
    .head    (q_head),
    .q_empty (q_empty),
    .pop     (q_pop),
    .results (results)
  );

endmodule

/* sv/gare_checker.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gare_checker
// port-level checks on the result channel
// ----------------------------------------------------------------------------
`include "grid_axis_reduce_expand_defines.svh"

module gare_checker import gare_pkg::*; (
  input logic                      clk,
  input logic                      rst,
  input logic                      out_valid,
  input logic                      out_ready,
  input logic signed [VALUE_W-1:0] out_value,
  input logic [POS_W-1:0]          out_x,
  input logic [POS_W-1:0]          out_y,
  input logic                      out_last
);

  `GARE_ASSERT_RESET(a_reset_empty, !out_valid, "result valid right after reset")

  `GARE_ASSERT_NEXT(a_valid_held, out_valid && !out_ready, out_valid, "result dropped while stalled")

  `GARE_ASSERT_NEXT(a_payload_held, out_valid && !out_ready, $stable(out_value) && $stable(out_x) && $stable(out_y) && $stable(out_last), "result changed while stalled")

  // a line copy keeps streaming the same value until its last cell
  `GARE_ASSERT_NEXT(a_copy_runs, out_valid && out_ready && !out_last, out_valid && out_value == $past(out_value), "line copy broken")

endmodule

bind grid_axis_reduce_expand gare_checker u_checker (
  .clk       (clk),
  .rst       (rst),
  .out_valid (results.valid),
  .out_ready (results.ready),
  .out_value (results.value),
  .out_x     (results.x_index),
  .out_y     (results.y_index),
  .out_last  (results.last)
);
